// File: rtl/core/pld_pkg.sv
// Shared types and constants for the 3D polyline decoder.
// No dependencies; imported by every module of the decoder.
package pld_pkg;

  // Character decoding constants
  localparam logic [7:0] CHAR_BIAS  = 8'd63;
  localparam logic [5:0] SHIFT_STEP = 6'd5;
  localparam int         SUM_W      = 32;

  // Which running sum a finished value goes to
  typedef enum logic [1:0] {
    SLOT_LAT = 2'd0,
    SLOT_LNG = 2'd1,
    SLOT_ELE = 2'd2
  } slot_t;

  // Operation handed from the front end to the back end
  typedef struct packed {
    logic [SUM_W-1:0] delta;      // zigzag-decoded value
    logic             has_value;  // delta is to be added
    slot_t            slot;       // target sum
    logic             point;      // this value completes a point
    logic             eol;        // last character of the string
  } op_t;

endpackage

// File: rtl/core/polyline_3d_decoder.sv
// Top level of the streaming 3D polyline decoder.
// Uses pld_pkg; instantiates pld_front, pld_queue and pld_back.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------------
//  in      | sink      | in_valid / in_stall | code_char, end_of_line
//  out     | source    | out_valid/out_stall | latitude, longitude, elevation,
//          |           |                     | last_point, truncated
//  cfg     | sink      | cfg_wr_en           | cfg_wr_data (three_d)
//
// One character per cycle is accepted while in_stall is low. The character that completes
// a point goes into a queue entry, then into the output register, which raises out_valid.
// in_stall is raised only while the QDEPTH-entry queue is full: the output register is
// held by out_stall, the result op at the queue head waits, and ops behind it fill the rest.
// Synchronous reset clears all sums, the chunk state and the queue; three_d goes to 1.
// No clearing pass after reset: the block takes characters the next cycle.
module polyline_3d_decoder
  import pld_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              code_char,
  input  logic                    end_of_line,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [SUM_W-1:0] latitude,
  output logic signed [SUM_W-1:0] longitude,
  output logic signed [SUM_W-1:0] elevation,
  output logic                    last_point,
  output logic                    truncated
);

  logic three_d;
  logic accept;
  logic push, pop, q_full, q_nonempty;
  op_t  push_op, head_op;

  // Mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      three_d <= 1'b1;
    end else if (cfg_wr_en) begin
      three_d <= cfg_wr_data;
    end
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  pld_front u_front (
    .clk         (clk),
    .rst         (rst),
    .three_d     (three_d),
    .accept      (accept),
    .code_char   (code_char),
    .end_of_line (end_of_line),
    .push        (push),
    .push_op     (push_op)
  );

  pld_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_op  (push_op),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head_op)
  );

  pld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .three_d    (three_d),
    .op_valid   (q_nonempty),
    .op         (head_op),
    .pop        (pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .latitude   (latitude),
    .longitude  (longitude),
    .elevation  (elevation),
    .last_point (last_point),
    .truncated  (truncated)
  );

endmodule

// File: rtl/core/pld_front.sv
// Front end: takes characters, gathers 5-bit chunks and zigzag-decodes values.
// Uses pld_pkg; feeds finished values and end-of-line marks to pld_queue.
module pld_front
  import pld_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       three_d,
  input  logic       accept,
  input  logic [7:0] code_char,
  input  logic       end_of_line,
  output logic       push,
  output op_t        push_op
);

  logic [SUM_W-1:0] chunk_value, chunk_value_next;
  logic [5:0]       chunk_shift, chunk_shift_next;
  slot_t            value_slot, value_slot_next;

  logic [7:0]       adj;
  logic             more;
  logic [SUM_W-1:0] gathered;
  logic [5:0]       shift_acc;
  logic [SUM_W-1:0] zz;
  logic             point;

  // Chunk gathering and zigzag decode
  always_comb begin
    adj       = code_char - CHAR_BIAS;
    more      = adj[5];
    gathered  = chunk_value;
    shift_acc = chunk_shift;
    if (!chunk_shift[5]) begin
      gathered  = chunk_value | ({{(SUM_W-5){1'b0}}, adj[4:0]} << chunk_shift[4:0]);
      shift_acc = chunk_shift + SHIFT_STEP;
    end
    zz = {gathered[SUM_W-1], gathered[SUM_W-1:1]};
    if (gathered[0]) begin
      zz = ~zz;
    end
  end

  // Slot sequencing and next state
  always_comb begin
    point            = 1'b0;
    chunk_value_next = gathered;
    chunk_shift_next = shift_acc;
    value_slot_next  = value_slot;
    push_op.delta     = zz;
    push_op.has_value = !more;
    push_op.slot      = SLOT_LAT;
    push_op.eol       = end_of_line;
    if (!more) begin
      chunk_value_next = '0;
      chunk_shift_next = '0;
      unique case (value_slot)
        SLOT_LNG: begin
          push_op.slot = SLOT_LNG;
          if (three_d) begin
            value_slot_next = SLOT_ELE;
          end else begin
            value_slot_next = SLOT_LAT;
            point           = 1'b1;
          end
        end
        SLOT_ELE: begin
          push_op.slot    = SLOT_ELE;
          value_slot_next = SLOT_LAT;
          point           = 1'b1;
        end
        default: begin
          push_op.slot    = SLOT_LAT;
          value_slot_next = SLOT_LNG;
        end
      endcase
    end
    if (end_of_line) begin
      chunk_value_next = '0;
      chunk_shift_next = '0;
      value_slot_next  = SLOT_LAT;
    end
    push_op.point = point;
    push          = accept && (!more || end_of_line);
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_value <= '0;
      chunk_shift <= '0;
      value_slot  <= SLOT_LAT;
    end else if (accept) begin
      chunk_value <= chunk_value_next;
      chunk_shift <= chunk_shift_next;
      value_slot  <= value_slot_next;
    end
  end

  // Shift saturates just past the word: 0, 5, ... 30, 35
  a_shift_bounded: assert property (@(posedge clk) disable iff (rst)
    chunk_shift <= 6'd35)
    else $error("chunk shift ran past its stop value");

endmodule

// File: rtl/core/pld_queue.sv
// Short operation queue between the decoder front end and back end.
// Uses pld_pkg for the op_t entry type.
module pld_queue
  import pld_pkg::*;
#(
  parameter int QDEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  input  logic pop,
  output logic full,
  output logic nonempty,
  output op_t  head
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QDEPTH);

  op_t              mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_FULL);
  assign nonempty = (count != '0);
  assign head     = mem[rd_ptr];

  // Storage write
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> nonempty)
    else $error("queue read while empty");

endmodule

// File: rtl/core/pld_back.sv
// Back end: applies decoded values to the running sums and emits points.
// Uses pld_pkg; takes operations from pld_queue, drives the output register.
module pld_back
  import pld_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    three_d,
  input  logic                    op_valid,
  input  op_t                     op,
  output logic                    pop,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [SUM_W-1:0] latitude,
  output logic signed [SUM_W-1:0] longitude,
  output logic signed [SUM_W-1:0] elevation,
  output logic                    last_point,
  output logic                    truncated
);

  logic [SUM_W-1:0] lat_sum, lng_sum, ele_sum;
  logic [SUM_W-1:0] lat_new, lng_new, ele_new;
  logic             needs_out;
  logic             out_free;
  logic             load;

  // Sum update for the head operation
  always_comb begin
    lat_new = lat_sum;
    lng_new = lng_sum;
    ele_new = ele_sum;
    if (op.has_value) begin
      case (op.slot)
        SLOT_LNG: lng_new = lng_sum + op.delta;
        SLOT_ELE: ele_new = ele_sum + op.delta;
        default:  lat_new = lat_sum + op.delta;
      endcase
    end
  end

  // Ops without a result never wait on the output side
  assign needs_out = op.point || op.eol;
  assign out_free  = !out_valid || !out_stall;
  assign pop       = op_valid && (!needs_out || out_free);
  assign load      = pop && needs_out;

  // Running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_sum <= '0;
      lng_sum <= '0;
      ele_sum <= '0;
    end else if (pop) begin
      if (op.eol) begin
        lat_sum <= '0;
        lng_sum <= '0;
        ele_sum <= '0;
      end else begin
        lat_sum <= lat_new;
        lng_sum <= lng_new;
        ele_sum <= ele_new;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_point <= op.eol;
      if (op.point) begin
        latitude  <= $signed(lat_new);
        longitude <= $signed(lng_new);
        elevation <= three_d ? $signed(ele_new) : '0;
        truncated <= 1'b0;
      end else begin
        latitude  <= '0;
        longitude <= '0;
        elevation <= '0;
        truncated <= 1'b1;
      end
    end
  end

  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    (pop && op.eol) |=> (lat_sum == '0 && lng_sum == '0 && ele_sum == '0))
    else $error("sums not cleared after end of line");

  a_trunc_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && truncated) |-> (last_point && latitude == '0 && longitude == '0))
    else $error("truncated result carries coordinates");

endmodule

// File: tb/sv/polyline_3d_decoder_checker.sv
// Checker for the 3D polyline decoder: tracks the input, output and config ports,
// predicts each result and compares it field by field. Depends on pld_pkg.
module polyline_3d_decoder_checker
  import pld_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic                    cfg_wr_data,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [7:0]              code_char,
  input  logic                    end_of_line,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic signed [SUM_W-1:0] latitude,
  input  logic signed [SUM_W-1:0] longitude,
  input  logic signed [SUM_W-1:0] elevation,
  input  logic                    last_point,
  input  logic                    truncated,
  output int                      pending,
  output int                      errors
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [SUM_W-1:0] lat;
    logic signed [SUM_W-1:0] lng;
    logic signed [SUM_W-1:0] ele;
    logic                    last;
    logic                    trunc;
  } fix_t;

  fix_t expected_fixes[$];

  // Predicted decoder state
  logic             mode_3d;
  logic [SUM_W-1:0] lat_acc, lng_acc, ele_acc;
  logic [SUM_W-1:0] gather;
  logic [5:0]       gather_pos;
  slot_t            next_slot;
  int               err_count = 0;

  assign errors = err_count;

  task automatic check_field(input string name, input logic signed [SUM_W-1:0] want,
                             input logic signed [SUM_W-1:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Sample every transfer at the clock edge, outputs before inputs
  always @(posedge clk) begin : track
    logic [7:0]       adj;
    logic [SUM_W-1:0] half, delta;
    logic             done_point;
    fix_t             want;
    if (rst) begin
      mode_3d    = 1'b1;
      lat_acc    = '0;
      lng_acc    = '0;
      ele_acc    = '0;
      gather     = '0;
      gather_pos = '0;
      next_slot  = SLOT_LAT;
      expected_fixes.delete();
    end else begin
      // Result transfer: compare with the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_fixes.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result, expected none, got %0d %0d %0d last %0b trunc %0b",
                   $time, latitude, longitude, elevation, last_point, truncated);
        end else begin
          want = expected_fixes.pop_front();
          check_field("latitude", want.lat, latitude);
          check_field("longitude", want.lng, longitude);
          check_field("elevation", want.ele, elevation);
          check_field("last_point", want.last, last_point);
          check_field("truncated", want.trunc, truncated);
        end
      end

      if (cfg_wr_en)
        mode_3d = cfg_wr_data;

      // Character transfer: gather the chunk, finish values and points
      if (in_valid && !in_stall) begin
        adj = code_char - CHAR_BIAS;
        done_point = 1'b0;
        // chunks past bit 31 are dropped and the position stops counting
        if (gather_pos < 6'd32) begin
          gather     = gather | (SUM_W'(adj[4:0]) << gather_pos);
          gather_pos = gather_pos + SHIFT_STEP;
        end
        if (!adj[5]) begin
          // zigzag with an arithmetic shift: bit 31 is kept
          half       = {gather[SUM_W-1], gather[SUM_W-1:1]};
          delta      = gather[0] ? ~half : half;
          gather     = '0;
          gather_pos = '0;
          case (next_slot)
            SLOT_LNG: begin
              lng_acc = lng_acc + delta;
              if (mode_3d) begin
                next_slot = SLOT_ELE;
              end else begin
                next_slot  = SLOT_LAT;
                done_point = 1'b1;
              end
            end
            SLOT_ELE: begin
              // finishes with elevation even if 3D mode was dropped meanwhile
              ele_acc    = ele_acc + delta;
              next_slot  = SLOT_LAT;
              done_point = 1'b1;
            end
            default: begin
              lat_acc   = lat_acc + delta;
              next_slot = SLOT_LNG;
            end
          endcase
        end
        if (done_point)
          expected_fixes.push_back('{lat: lat_acc, lng: lng_acc,
                                     ele: mode_3d ? ele_acc : '0,
                                     last: end_of_line, trunc: 1'b0});
        else if (end_of_line)
          expected_fixes.push_back('{lat: '0, lng: '0, ele: '0, last: 1'b1, trunc: 1'b1});
        // end of line clears everything but the mode
        if (end_of_line) begin
          lat_acc    = '0;
          lng_acc    = '0;
          ele_acc    = '0;
          gather     = '0;
          gather_pos = '0;
          next_slot  = SLOT_LAT;
        end
      end
    end
    pending <= expected_fixes.size();
  end

endmodule

// File: tb/sv/tb_polyline_3d_decoder.sv
// Testbench top for the 3D polyline decoder: clock, reset, character stimulus,
// output stall pattern and verdict. Depends on pld_pkg and polyline_3d_decoder_checker.
module tb_polyline_3d_decoder;
  import pld_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                    clk;
  logic                    rst         = 1'b1;
  logic                    cfg_wr_en   = 1'b0;
  logic                    cfg_wr_data = 1'b0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic [7:0]              code_char   = '0;
  logic                    end_of_line = 1'b0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic signed [SUM_W-1:0] latitude, longitude, elevation;
  logic                    last_point, truncated;

  int   pending;
  int   errors;
  int   chars_sent = 0;
  logic cur_mode   = 1'b1;
  logic quiet      = 1'b0;   // no idling on either side while set
  logic hold_req   = 1'b0;   // asks the receiver for its one long hold-off
  logic [7:0] text_q[$];

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  polyline_3d_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .code_char  (code_char),
    .end_of_line(end_of_line),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .latitude   (latitude),
    .longitude  (longitude),
    .elevation  (elevation),
    .last_point (last_point),
    .truncated  (truncated)
  );

  polyline_3d_decoder_checker u_checker (.*);

  // Receiver: random stalls, one long hold-off so the queue fills
  int   hold_left = 0;
  logic hold_used = 1'b0;
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= 80;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 13);
    end
  end

  // One character transfer, with an occasional idle gap first
  task automatic send_char(input logic [7:0] c, input logic e);
    if (!quiet && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    code_char   <= c;
    end_of_line <= e;
    do @(posedge clk); while (in_stall);
    chars_sent++;
  endtask

  task automatic send_text(input logic eol_last);
    foreach (text_q[i])
      send_char(text_q[i], eol_last && (i == text_q.size() - 1));
    text_q.delete();
  endtask

  // Mode write once every expected result is out and the pipeline has drained
  task automatic set_mode(input logic v);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_mode = v;
  endtask

  // Append one encoded value: zigzag, then 5-bit chunks low first
  function automatic void append_value(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] u;
    u = {v[SUM_W-2:0], 1'b0} ^ {SUM_W{v[SUM_W-1]}};
    while (u >= 32) begin
      text_q.push_back({3'b001, u[4:0]} + CHAR_BIAS);
      u = u >> 5;
    end
    text_q.push_back({3'b000, u[4:0]} + CHAR_BIAS);
  endfunction

  // Well-formed points with random deltas, mostly small
  task automatic build_points(input int npts);
    logic [SUM_W-1:0] mag;
    for (int p = 0; p < npts; p++) begin
      for (int k = 0; k < (cur_mode ? 3 : 2); k++) begin
        case ($urandom_range(9))
          0, 1, 2, 3, 4, 5, 6: mag = $urandom_range(2000);
          7, 8:                mag = $urandom_range(1 << 20);
          default:             mag = $urandom;
        endcase
        append_value($urandom_range(1) ? -mag : mag);
      end
    end
  endtask

  initial begin
    int phase;
    int cut;
    int nchars;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero point, then a value longer than 32 bits, bytes below and far above the bias
    send_char("?", 1'b0);
    send_char("?", 1'b0);
    send_char("?", 1'b0);
    repeat (7) send_char("~", 1'b0);
    send_char("^", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hff, 1'b0);
    // string ends after latitude only, then a point ending the string
    send_char("?", 1'b1);
    send_char("?", 1'b0);
    send_char("?", 1'b0);
    send_char("?", 1'b1);
    // string ends in the middle of a value
    send_char("_", 1'b1);
    // mode dropped while the elevation is still to come
    send_char("A", 1'b0);
    send_char("A", 1'b0);
    set_mode(1'b0);
    send_char("A", 1'b0);
    // 2D point ending the string
    send_char("?", 1'b0);
    send_char("C", 1'b1);

    // Random phases, each with its own mode
    chars_sent = 0;
    phase = 0;
    while (chars_sent < 1100) begin
      set_mode($urandom_range(1));
      if (phase == 2)
        hold_req <= 1'b1;
      if (phase == 3)
        quiet <= 1'b1;
      else if (phase == 6)
        quiet <= 1'b0;
      repeat ($urandom_range(4, 12)) begin
        case ($urandom_range(9))
          8: begin
            // broken string: cut short, not always closed by end of line
            build_points($urandom_range(1, 3));
            cut = $urandom_range(1, text_q.size() - 1);
            while (text_q.size() > cut)
              void'(text_q.pop_back());
            send_text($urandom_range(1));
          end
          9: begin
            // noise bytes, closed by end of line
            nchars = $urandom_range(3, 15);
            for (int i = 0; i < nchars; i++)
              send_char($urandom_range(255), (i == nchars - 1) || ($urandom_range(9) == 0));
          end
          default: begin
            build_points($urandom_range(1, 5));
            send_text(1'b1);
          end
        endcase
      end
      phase++;
    end

    // Drain and give the verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/pld_pkg.sv
rtl/core/pld_front.sv
rtl/core/pld_queue.sv
rtl/core/pld_back.sv
rtl/core/polyline_3d_decoder.sv
tb/sv/polyline_3d_decoder_checker.sv
tb/sv/tb_polyline_3d_decoder.sv
